FILE: hdl/link_supervisor_fsm_unit_assert.svh
// Assertion macros for the link supervisor.
`ifndef LINK_SUPERVISOR_FSM_UNIT_ASSERT_SVH
`define LINK_SUPERVISOR_FSM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSUP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link supervisor: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LSUP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link supervisor: next-cycle check failed");

`endif

FILE: hdl/link_sup_pkg.sv
`timescale 1ns / 1ps

package link_sup_pkg;

   typedef enum logic [1:0] {
      MODE_BOOT = 2'd0,
      MODE_AP   = 2'd1,
      MODE_STA  = 2'd2,
      MODE_RUN  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_START_AP  = 2'd1,
      OP_START_STA = 2'd2,
      OP_STOP_AP   = 2'd3
   } op_type;

   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOOT_WAIT       = 3'd0,
      CSR_AP_TIMEOUT      = 3'd1,
      CSR_CONNECT_TIMEOUT = 3'd2,
      CSR_RETRY_LIMIT     = 3'd3,
      CSR_DEBOUNCE        = 3'd4,
      CSR_HOLD            = 3'd5
   } csr_index_type;

   localparam logic [31:0] BOOT_WAIT_RST       = 32'd3000;
   localparam logic [31:0] AP_TIMEOUT_RST      = 32'd120000;
   localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd20000;
   localparam logic [7:0]  RETRY_LIMIT_RST     = 8'd3;
   localparam logic [31:0] DEBOUNCE_RST        = 32'd5000;
   localparam logic [31:0] HOLD_RST            = 32'd5000;

   typedef struct packed {
      logic       link_up;
      logic       config_saved;
      logic       creds_valid;
      logic       button_held;
      logic [1:0] operation;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       start_ap;
      logic       start_sta;
      logic       restart_req;
      logic       clear_saved;
      logic       radio_off;
      logic [7:0] retry_count;
   } rsp_type;

   // saturating tick counter increment
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

FILE: hdl/link_supervisor_fsm_unit.sv
`timescale 1ns / 1ps
// Link supervisor: one request beat per millisecond tick, one response beat per request.
// Request channel (req_valid/req_ready/req_data): link status, saved-config and
// credential flags, button level and an external operation code.
// Response channel (rsp_valid/rsp_ready/rsp_data): mode after the tick, the
// start_ap/start_sta/restart_req/clear_saved/radio_off pulses and the retry count.
// CSR channel (csr_valid/csr_ready/csr_index/csr_data): six timing and limit
// registers, always ready; write only while no beat is outstanding.
// Registered: the response beat appears in the cycle after its request beat is taken.
// Throughput: one beat per cycle unless the receiver stalls; the tick update is a single
// pass of counter increments and 32-bit compares between state and response registers.
// A request is taken whenever the response register is empty or drains in the
// same cycle, so a stalled receiver holds one response and back-pressures the
// request side.
// Reset (synchronous, active high): boot mode, all timers and the retry count
// cleared, the registers at their default values, no response pending.
`include "link_supervisor_fsm_unit_assert.svh"

module link_supervisor_fsm_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  link_sup_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output link_sup_pkg::rsp_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [link_sup_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                         csr_data
);

   // configuration registers
   logic [31:0] boot_wait_ff, ap_timeout_ff, connect_timeout_ff;
   logic [31:0] debounce_ff, hold_ff;
   logic [7:0]  retry_limit_ff;

   // supervisor state
   link_sup_pkg::mode_type mode_ff, mode_in;
   logic [31:0] mode_elapsed_ff, mode_elapsed_in;
   logic [31:0] press_elapsed_ff, press_elapsed_in;
   logic        press_seen_ff, press_seen_in;
   logic [31:0] down_elapsed_ff, down_elapsed_in;
   logic        down_seen_ff, down_seen_in;
   logic [7:0]  attempts_ff, attempts_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   link_sup_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_take;
   logic start_ap, start_sta, restart_req, clear_saved, radio_off;

   // take a new beat when the output slot is empty or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // CSR writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         boot_wait_ff       <= link_sup_pkg::BOOT_WAIT_RST;
         ap_timeout_ff      <= link_sup_pkg::AP_TIMEOUT_RST;
         connect_timeout_ff <= link_sup_pkg::CONNECT_TIMEOUT_RST;
         retry_limit_ff     <= link_sup_pkg::RETRY_LIMIT_RST;
         debounce_ff        <= link_sup_pkg::DEBOUNCE_RST;
         hold_ff            <= link_sup_pkg::HOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (link_sup_pkg::csr_index_type'(csr_index))
            link_sup_pkg::CSR_BOOT_WAIT:       boot_wait_ff       <= csr_data;
            link_sup_pkg::CSR_AP_TIMEOUT:      ap_timeout_ff      <= csr_data;
            link_sup_pkg::CSR_CONNECT_TIMEOUT: connect_timeout_ff <= csr_data;
            link_sup_pkg::CSR_RETRY_LIMIT:     retry_limit_ff     <= csr_data[7:0];
            link_sup_pkg::CSR_DEBOUNCE:        debounce_ff        <= csr_data;
            link_sup_pkg::CSR_HOLD:            hold_ff            <= csr_data;
            default: ;
         endcase
      end
   end

   // One tick of the supervisor: operation, then button hold, then mode rules.
   // Each step sees the mode and timers left by the step before it.
   always_comb begin
      mode_in          = mode_ff;
      press_elapsed_in = press_elapsed_ff;
      press_seen_in    = press_seen_ff;
      down_seen_in     = down_seen_ff;
      attempts_in      = attempts_ff;
      start_ap         = 1'b0;
      start_sta        = 1'b0;
      restart_req      = 1'b0;
      clear_saved      = 1'b0;
      radio_off        = 1'b0;

      // advance the mode timer, and the down timer while a link drop is seen
      mode_elapsed_in = link_sup_pkg::sat_inc(mode_elapsed_ff);
      down_elapsed_in = down_seen_ff ? link_sup_pkg::sat_inc(down_elapsed_ff)
                                     : down_elapsed_ff;

      // external operation
      unique case (link_sup_pkg::op_type'(req_data.operation))
         link_sup_pkg::OP_START_AP: begin
            if (mode_in != link_sup_pkg::MODE_AP) begin
               mode_in = link_sup_pkg::MODE_AP;
               mode_elapsed_in = '0;
               start_ap = 1'b1;
            end
         end
         link_sup_pkg::OP_START_STA: begin
            if (mode_in != link_sup_pkg::MODE_STA) begin
               mode_elapsed_in = '0;
               if (req_data.creds_valid) begin
                  mode_in = link_sup_pkg::MODE_STA;
                  start_sta = 1'b1;
               end else begin
                  // bad credentials: fall into AP, pulsing even if already there
                  mode_in = link_sup_pkg::MODE_AP;
                  start_ap = 1'b1;
               end
            end
         end
         link_sup_pkg::OP_STOP_AP: begin
            // back to boot, keeping the timer so the boot wait counts from AP entry
            if (mode_in == link_sup_pkg::MODE_AP) begin
               mode_in = link_sup_pkg::MODE_BOOT;
               radio_off = 1'b1;
            end
         end
         default: ;
      endcase

      // button hold
      if (req_data.button_held) begin
         if (!press_seen_in) begin
            press_seen_in = 1'b1;
            press_elapsed_in = '0;
         end else begin
            press_elapsed_in = link_sup_pkg::sat_inc(press_elapsed_in);
         end
         if (press_elapsed_in >= hold_ff) begin
            clear_saved = 1'b1;
            press_seen_in = 1'b0;
            if (mode_in != link_sup_pkg::MODE_AP) begin
               mode_in = link_sup_pkg::MODE_AP;
               mode_elapsed_in = '0;
               start_ap = 1'b1;
            end
         end
      end else begin
         press_seen_in = 1'b0;
      end

      // mode rules
      unique case (mode_in)
         link_sup_pkg::MODE_BOOT: begin
            if (mode_elapsed_in > boot_wait_ff) begin
               mode_elapsed_in = '0;
               if (req_data.config_saved && req_data.creds_valid) begin
                  mode_in = link_sup_pkg::MODE_STA;
                  start_sta = 1'b1;
               end else begin
                  mode_in = link_sup_pkg::MODE_AP;
                  start_ap = 1'b1;
               end
            end
         end
         link_sup_pkg::MODE_AP: begin
            if (mode_elapsed_in > ap_timeout_ff) begin
               restart_req = 1'b1;
            end
         end
         link_sup_pkg::MODE_STA: begin
            if (req_data.link_up) begin
               attempts_in = '0;
               mode_in = link_sup_pkg::MODE_RUN;
            end else if (mode_elapsed_in > connect_timeout_ff) begin
               mode_elapsed_in = '0;
               if (attempts_in >= retry_limit_ff) begin
                  // out of retries: fall back to AP
                  attempts_in = '0;
                  mode_in = link_sup_pkg::MODE_AP;
                  start_ap = 1'b1;
               end else begin
                  // retry: restart timer; station start if creds valid, else AP
                  if (attempts_in != 8'hFF) begin
                     attempts_in = attempts_in + 8'd1;
                  end
                  if (req_data.creds_valid) begin
                     start_sta = 1'b1;
                  end else begin
                     mode_in = link_sup_pkg::MODE_AP;
                     start_ap = 1'b1;
                  end
               end
            end
         end
         link_sup_pkg::MODE_RUN: begin
            if (!req_data.link_up) begin
               if (!down_seen_in) begin
                  down_seen_in = 1'b1;
                  down_elapsed_in = '0;
               end
               if (down_elapsed_in > debounce_ff) begin
                  attempts_in = '0;
                  down_seen_in = 1'b0;
                  mode_elapsed_in = '0;
                  if (req_data.creds_valid) begin
                     mode_in = link_sup_pkg::MODE_STA;
                     start_sta = 1'b1;
                  end else begin
                     mode_in = link_sup_pkg::MODE_AP;
                     start_ap = 1'b1;
                  end
               end
            end else begin
               down_seen_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // pack the response and manage the output slot
   always_comb begin
      rsp_data_in.mode        = mode_in;
      rsp_data_in.start_ap    = start_ap;
      rsp_data_in.start_sta   = start_sta;
      rsp_data_in.restart_req = restart_req;
      rsp_data_in.clear_saved = clear_saved;
      rsp_data_in.radio_off   = radio_off;
      rsp_data_in.retry_count = attempts_in;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= link_sup_pkg::MODE_BOOT;
         mode_elapsed_ff  <= '0;
         press_elapsed_ff <= '0;
         press_seen_ff    <= 1'b0;
         down_elapsed_ff  <= '0;
         down_seen_ff     <= 1'b0;
         attempts_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            mode_ff          <= mode_in;
            mode_elapsed_ff  <= mode_elapsed_in;
            press_elapsed_ff <= press_elapsed_in;
            press_seen_ff    <= press_seen_in;
            down_elapsed_ff  <= down_elapsed_in;
            down_seen_ff     <= down_seen_in;
            attempts_ff      <= attempts_in;
         end
      end
   end

   // response payload: load on a taken beat, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `LSUP_ASSERT_IMP(a_start_ap_in_ap, clock, reset,
      rsp_valid_ff && rsp_data_ff.start_ap, rsp_data_ff.mode == link_sup_pkg::MODE_AP)
   `LSUP_ASSERT_IMP(a_start_sta_mode, clock, reset,
      rsp_valid_ff && rsp_data_ff.start_sta,
      rsp_data_ff.mode != link_sup_pkg::MODE_BOOT)
   `LSUP_ASSERT_IMP(a_radio_off_not_run, clock, reset,
      rsp_valid_ff && rsp_data_ff.radio_off, rsp_data_ff.mode != link_sup_pkg::MODE_RUN)
   `LSUP_ASSERT_IMP(a_mode_tracks_state, clock, reset,
      rsp_valid_ff, rsp_data_ff.mode == mode_ff && rsp_data_ff.retry_count == attempts_ff)
   `LSUP_ASSERT_NXT(a_take_fills_slot, clock, reset, req_take, rsp_valid_ff)

endmodule
